@@ hw/rtl/aabb_collide_push_out_macros.svh @@
// Assertion macros shared by the collision block.
`ifndef AABB_COLLIDE_PUSH_OUT_MACROS_SVH
`define AABB_COLLIDE_PUSH_OUT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define AABB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("aabb_collide_push_out: check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define AABB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("aabb_collide_push_out: check failed");

`endif

@@ hw/rtl/aabb_pkg.sv @@
// Shared widths and pipeline types for the rectangle collision block.
`default_nettype none

package aabb_pkg;

  // Coordinate width; half extents are two bits narrower, pushes two wider.
  localparam int COORD_BITS = 24;
  localparam int HALF_BITS  = COORD_BITS - 2;
  localparam int SIDE_BITS  = COORD_BITS + 1;
  localparam int PUSH_BITS  = COORD_BITS + 2;

  // One registered input word.
  typedef struct packed {
    logic signed [COORD_BITS-1:0] a_center_x;
    logic signed [COORD_BITS-1:0] a_center_y;
    logic        [HALF_BITS-1:0]  a_half_width;
    logic        [HALF_BITS-1:0]  a_half_height;
    logic signed [COORD_BITS-1:0] b_center_x;
    logic signed [COORD_BITS-1:0] b_center_y;
    logic        [HALF_BITS-1:0]  b_half_width;
    logic        [HALF_BITS-1:0]  b_half_height;
  } rect_pair_t;

  // Side overlaps and the hit flag, passed from the overlap stage to selection.
  typedef struct packed {
    logic                        hit;
    logic signed [PUSH_BITS-1:0] right;
    logic signed [PUSH_BITS-1:0] top;
    logic signed [PUSH_BITS-1:0] left;
    logic signed [PUSH_BITS-1:0] bottom;
  } overlap_t;

endpackage

`default_nettype wire

@@ hw/rtl/aabb_overlap.sv @@
// Edge positions, corner containment test and the four side overlaps.
`default_nettype none

module aabb_overlap (
  input  aabb_pkg::rect_pair_t pair,
  output aabb_pkg::overlap_t   ovl
);

  logic signed [aabb_pkg::SIDE_BITS-1:0] a_xl, a_xh, a_yl, a_yh;
  logic signed [aabb_pkg::SIDE_BITS-1:0] b_xl, b_xh, b_yl, b_yh;
  logic a_x_in, a_y_in, b_x_in, b_y_in;

  // Rectangle edges, one bit wider than the coordinates.
  always_comb begin
    a_xl = aabb_pkg::SIDE_BITS'(pair.a_center_x) - aabb_pkg::SIDE_BITS'(pair.a_half_width);
    a_xh = aabb_pkg::SIDE_BITS'(pair.a_center_x) + aabb_pkg::SIDE_BITS'(pair.a_half_width);
    a_yl = aabb_pkg::SIDE_BITS'(pair.a_center_y) - aabb_pkg::SIDE_BITS'(pair.a_half_height);
    a_yh = aabb_pkg::SIDE_BITS'(pair.a_center_y) + aabb_pkg::SIDE_BITS'(pair.a_half_height);
    b_xl = aabb_pkg::SIDE_BITS'(pair.b_center_x) - aabb_pkg::SIDE_BITS'(pair.b_half_width);
    b_xh = aabb_pkg::SIDE_BITS'(pair.b_center_x) + aabb_pkg::SIDE_BITS'(pair.b_half_width);
    b_yl = aabb_pkg::SIDE_BITS'(pair.b_center_y) - aabb_pkg::SIDE_BITS'(pair.b_half_height);
    b_yh = aabb_pkg::SIDE_BITS'(pair.b_center_y) + aabb_pkg::SIDE_BITS'(pair.b_half_height);
  end

  // A corner lies strictly inside when one of its edge coordinates sits in the
  // open interval of the other rectangle on both axes. Covering either edge on
  // each axis covers all four corners.
  always_comb begin
    a_x_in = (a_xl > b_xl && a_xl < b_xh) || (a_xh > b_xl && a_xh < b_xh);
    a_y_in = (a_yl > b_yl && a_yl < b_yh) || (a_yh > b_yl && a_yh < b_yh);
    b_x_in = (b_xl > a_xl && b_xl < a_xh) || (b_xh > a_xl && b_xh < a_xh);
    b_y_in = (b_yl > a_yl && b_yl < a_yh) || (b_yh > a_yl && b_yh < a_yh);
  end

  // Side overlaps, two bits wider than the coordinates so nothing wraps.
  always_comb begin
    ovl.hit    = (a_x_in && a_y_in) || (b_x_in && b_y_in);
    ovl.right  = aabb_pkg::PUSH_BITS'(a_xh) - aabb_pkg::PUSH_BITS'(b_xl);
    ovl.top    = aabb_pkg::PUSH_BITS'(a_yh) - aabb_pkg::PUSH_BITS'(b_yl);
    ovl.left   = aabb_pkg::PUSH_BITS'(a_xl) - aabb_pkg::PUSH_BITS'(b_xh);
    ovl.bottom = aabb_pkg::PUSH_BITS'(a_yl) - aabb_pkg::PUSH_BITS'(b_yh);
  end

endmodule

`default_nettype wire

@@ hw/rtl/aabb_select.sv @@
// Picks the smaller push-out from the four side overlaps.
`default_nettype none

module aabb_select (
  input  aabb_pkg::overlap_t                    ovl,
  output logic                                  hit,
  output logic signed [aabb_pkg::PUSH_BITS-1:0] push_x,
  output logic signed [aabb_pkg::PUSH_BITS-1:0] push_y
);

  logic signed [aabb_pkg::PUSH_BITS-1:0] max_rl, max_tb, m;
  logic signed [aabb_pkg::PUSH_BITS-1:0] hi_r, hi, lo_l, lo, lo_mag;

  // Largest of the four overlaps seeds both bounds.
  always_comb begin
    max_rl = (ovl.right > ovl.left)  ? ovl.right : ovl.left;
    max_tb = (ovl.top > ovl.bottom)  ? ovl.top   : ovl.bottom;
    m      = (max_rl > max_tb)       ? max_rl    : max_tb;
  end

  // Smallest positive right/top and largest negative left/bottom.
  always_comb begin
    hi_r   = (ovl.right > 0 && ovl.right < m) ? ovl.right : m;
    hi     = (ovl.top > 0 && ovl.top < hi_r) ? ovl.top : hi_r;
    lo_l   = (ovl.left < 0 && ovl.left > -m) ? ovl.left : -m;
    lo     = (ovl.bottom < 0 && ovl.bottom > lo_l) ? ovl.bottom : lo_l;
    lo_mag = (lo < 0) ? -lo : lo;
  end

  // Push along the smaller magnitude; a tie in magnitude gives no push.
  always_comb begin
    hit    = ovl.hit;
    push_x = '0;
    push_y = '0;
    if (ovl.hit) begin
      if (hi < lo_mag) begin
        if (ovl.right == hi) push_x = -hi;
        if (ovl.top == hi)   push_y = -hi;
      end else if (hi > lo_mag) begin
        if (ovl.left == lo)   push_x = -lo;
        if (ovl.bottom == lo) push_y = -lo;
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/aabb_collide_push_out.sv @@
// Top level of the rectangle collision and push-out block.
//
// Takes one pair of rectangles per clock: a word is accepted on every rising
// edge with start high, and busy never rises. Each word gives exactly one
// result, shown for one cycle with done high; the receiver cannot stall, so
// it must take hit, push_x and push_y in that cycle. A word passes the input
// register, the overlap register and the result register in turn; edge sums
// and the containment test sit in the first stage, the min/max selection in
// the second.
`default_nettype none
`include "aabb_collide_push_out_macros.svh"

module aabb_collide_push_out (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [aabb_pkg::COORD_BITS-1:0] a_center_x,
  input  logic signed [aabb_pkg::COORD_BITS-1:0] a_center_y,
  input  logic        [aabb_pkg::HALF_BITS-1:0]  a_half_width,
  input  logic        [aabb_pkg::HALF_BITS-1:0]  a_half_height,
  input  logic signed [aabb_pkg::COORD_BITS-1:0] b_center_x,
  input  logic signed [aabb_pkg::COORD_BITS-1:0] b_center_y,
  input  logic        [aabb_pkg::HALF_BITS-1:0]  b_half_width,
  input  logic        [aabb_pkg::HALF_BITS-1:0]  b_half_height,
  output logic                                   done,
  output logic                                   hit,
  output logic signed [aabb_pkg::PUSH_BITS-1:0]  push_x,
  output logic signed [aabb_pkg::PUSH_BITS-1:0]  push_y
);

  aabb_pkg::rect_pair_t                  pair;
  aabb_pkg::overlap_t                    ovl_next, ovl;
  logic                                  pair_valid, ovl_valid;
  logic                                  hit_next;
  logic signed [aabb_pkg::PUSH_BITS-1:0] push_x_next, push_y_next;

  // Every cycle takes a new word.
  assign busy = 1'b0;

  // Stage valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      pair_valid <= 1'b0;
      ovl_valid  <= 1'b0;
      done       <= 1'b0;
    end else begin
      pair_valid <= start;
      ovl_valid  <= pair_valid;
      done       <= ovl_valid;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (start) begin
      pair.a_center_x    <= a_center_x;
      pair.a_center_y    <= a_center_y;
      pair.a_half_width  <= a_half_width;
      pair.a_half_height <= a_half_height;
      pair.b_center_x    <= b_center_x;
      pair.b_center_y    <= b_center_y;
      pair.b_half_width  <= b_half_width;
      pair.b_half_height <= b_half_height;
    end
  end

  aabb_overlap u_overlap (
    .pair (pair),
    .ovl  (ovl_next)
  );

  // Overlap register.
  always_ff @(posedge clk) begin
    if (pair_valid) begin
      ovl <= ovl_next;
    end
  end

  aabb_select u_select (
    .ovl    (ovl),
    .hit    (hit_next),
    .push_x (push_x_next),
    .push_y (push_y_next)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (ovl_valid) begin
      hit    <= hit_next;
      push_x <= push_x_next;
      push_y <= push_y_next;
    end
  end

  // Every accepted word comes out with done high, and done rises only for an accepted word.
  `AABB_ASSERT_NEXT(a_start_to_done, start, ##2 done)
  `AABB_ASSERT_IMP(a_done_from_start, done, $past(start, 3))
  // A miss never pushes.
  `AABB_ASSERT_IMP(a_miss_no_push, done && !hit, push_x == '0 && push_y == '0)
  // Both axes push only on a tie, and then by the same amount.
  `AABB_ASSERT_IMP(a_both_axes_tie, done && push_x != '0 && push_y != '0, push_x == push_y)

endmodule

`default_nettype wire
